// ----- design/ps2md_pkg.sv -----
`default_nettype none

package ps2md_pkg;

	localparam int COORD_MAX    = 4095;
	localparam int CUR_W        = $clog2(COORD_MAX + 1);
	localparam int POS_W        = 12;
	localparam int ACC_W        = 16;
	localparam int LIM_W        = 9;
	localparam int DELTA_W      = LIM_W + 1;
	localparam int BYTE_W       = 8;
	localparam int BTN_W        = 3;
	localparam int IDX_W        = 2;
	localparam int PKT_DEPTH    = 3;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = LIM_W;
	localparam int CMDQ_DEPTH   = 2;
	localparam int CMDQ_PTR_W   = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CNT_W   = $clog2(CMDQ_DEPTH + 1);
	localparam int OBUF_DEPTH   = 2;
	localparam int OBUF_PTR_W   = $clog2(OBUF_DEPTH);
	localparam int OBUF_CNT_W   = $clog2(OBUF_DEPTH + 1);

	localparam logic [CUR_W-1:0] CURSOR_RESET = CUR_W'((COORD_MAX + 1) / 2);
	localparam logic [LIM_W-1:0] LIMIT_RESET  = LIM_W'(96);

	// byte positions inside a packet
	localparam logic [IDX_W-1:0] IDX_FIRST   = 2'd0;
	localparam logic [IDX_W-1:0] IDX_DY      = 2'd2;
	localparam logic [IDX_W-1:0] IDX_WHEEL   = 2'd3;
	localparam logic [IDX_W-1:0] LAST_SHORT  = 2'd2;
	localparam logic [IDX_W-1:0] LAST_LONG   = 2'd3;

	// first byte flag bits
	localparam int SYNC_BIT  = 3;
	localparam int XSIGN_BIT = 4;
	localparam int YSIGN_BIT = 5;
	localparam int XOVF_BIT  = 6;
	localparam int YOVF_BIT  = 7;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WHEEL_MODE  = 1'b0,
		REG_DELTA_LIMIT = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		CMD_NOP    = 2'd0,
		CMD_READ   = 2'd1,
		CMD_PACKET = 2'd2
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t                   op;
		logic                      clr_motion;
		logic                      clr_wheel;
		logic [BTN_W-1:0]          buttons;
		logic signed [DELTA_W-1:0] dx;
		logic signed [DELTA_W-1:0] dy;
		logic                      use_wheel;
		logic signed [BYTE_W-1:0]  wz;
	} cmd_t;

	typedef struct packed {
		logic [POS_W-1:0]        pos_x;
		logic [POS_W-1:0]        pos_y;
		logic [BTN_W-1:0]        buttons;
		logic signed [ACC_W-1:0] sum_dx;
		logic signed [ACC_W-1:0] sum_dy;
		logic signed [ACC_W-1:0] sum_wheel;
		logic                    packet_done;
	} res_t;

	function automatic logic signed [DELTA_W-1:0] clamp_delta(
		input logic signed [DELTA_W-1:0] d,
		input logic [LIM_W-1:0]          lim
	);
		logic signed [DELTA_W-1:0] lim_s;
		lim_s = signed'({1'b0, lim});
		if (d > lim_s)
			return lim_s;
		else if (d < -lim_s)
			return -lim_s;
		else
			return d;
	endfunction

	function automatic logic [CUR_W-1:0] move_cursor(
		input logic [CUR_W-1:0]          cur,
		input logic signed [DELTA_W-1:0] d
	);
		logic signed [CUR_W+1:0] sum;
		sum = signed'({2'b00, cur}) + (CUR_W+2)'(d);
		if (sum < 0)
			return '0;
		else if (sum > (CUR_W+2)'(COORD_MAX))
			return CUR_W'(COORD_MAX);
		else
			return sum[CUR_W-1:0];
	endfunction

	function automatic logic signed [ACC_W-1:0] sat_add(
		input logic signed [ACC_W-1:0]   acc,
		input logic signed [DELTA_W-1:0] d
	);
		logic signed [ACC_W:0] sum;
		sum = (ACC_W+1)'(acc) + (ACC_W+1)'(d);
		if (sum[ACC_W] != sum[ACC_W-1])
			return sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		else
			return sum[ACC_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ----- design/ps2md_front.sv -----
`default_nettype none

module ps2md_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        wheel_mode,
	input  wire logic [ps2md_pkg::LIM_W-1:0] delta_limit,
	input  wire logic                        take,
	input  wire logic                        kind,
	input  wire logic [7:0]                  data_byte,
	input  wire logic                        clear_motion,
	input  wire logic                        clear_wheel,
	output ps2md_pkg::cmd_t                  cmd
);
	import ps2md_pkg::*;

	logic [IDX_W-1:0]  byte_idx_q;
	logic [BYTE_W-1:0] pkt_q [PKT_DEPTH];

	logic                      out_of_sync;
	logic                      finish;
	logic [BYTE_W-1:0]         b0;
	logic [BYTE_W-1:0]         b1;
	logic [BYTE_W-1:0]         b2;
	logic signed [DELTA_W-1:0] dx_raw;
	logic signed [DELTA_W-1:0] dy_raw;

	assign out_of_sync = (byte_idx_q == IDX_FIRST) && !data_byte[SYNC_BIT];
	assign finish      = byte_idx_q >= (wheel_mode ? LAST_LONG : LAST_SHORT);

	// the y byte may be arriving right now
	assign b0 = pkt_q[0];
	assign b1 = pkt_q[1];
	assign b2 = (byte_idx_q == IDX_DY) ? data_byte : pkt_q[2];

	assign dx_raw = b0[XOVF_BIT] ? '0 : signed'({b0[XSIGN_BIT], b0[XSIGN_BIT], b1});
	assign dy_raw = b0[YOVF_BIT] ? '0 : signed'({b0[YSIGN_BIT], b0[YSIGN_BIT], b2});

	always_comb begin
		cmd.clr_motion = clear_motion;
		cmd.clr_wheel  = clear_wheel;
		cmd.buttons    = b0[BTN_W-1:0];
		cmd.dx         = clamp_delta(dx_raw, delta_limit);
		cmd.dy         = -clamp_delta(dy_raw, delta_limit);
		cmd.use_wheel  = wheel_mode && (byte_idx_q == IDX_WHEEL);
		cmd.wz         = signed'(data_byte);
		if (kind)
			cmd.op = CMD_READ;
		else if (!out_of_sync && finish)
			cmd.op = CMD_PACKET;
		else
			cmd.op = CMD_NOP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_idx_q <= IDX_FIRST;
		end else if (take && !kind && !out_of_sync) begin
			byte_idx_q <= finish ? IDX_FIRST : byte_idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take && !kind && !out_of_sync && byte_idx_q < IDX_WHEEL) begin
			pkt_q[byte_idx_q] <= data_byte;
		end
	end

endmodule

`default_nettype wire

// ----- design/ps2md_cmd_fifo.sv -----
`default_nettype none

module ps2md_cmd_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr_en,
	input  wire ps2md_pkg::cmd_t wr_data,
	input  wire logic            rd_en,
	output ps2md_pkg::cmd_t      rd_data,
	output logic                 q_full,
	output logic                 q_empty
);
	import ps2md_pkg::*;

	cmd_t                  slot_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q;
	logic [CMDQ_PTR_W-1:0] rd_ptr_q;
	logic [CMDQ_CNT_W-1:0] cnt_q;

	logic do_wr;
	logic do_rd;

	assign q_full  = cnt_q == CMDQ_CNT_W'(CMDQ_DEPTH);
	assign q_empty = cnt_q == '0;
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			slot_q[wr_ptr_q] <= wr_data;
	end

endmodule

`default_nettype wire

// ----- design/ps2md_back.sv -----
`default_nettype none

module ps2md_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cmd_empty,
	input  wire ps2md_pkg::cmd_t cmd,
	output logic                 cmd_pop,
	input  wire logic            res_pop,
	output ps2md_pkg::res_t      res,
	output logic                 res_empty
);
	import ps2md_pkg::*;

	logic [CUR_W-1:0]        cursor_x_q;
	logic [CUR_W-1:0]        cursor_y_q;
	logic [BTN_W-1:0]        buttons_q;
	logic signed [ACC_W-1:0] acc_dx_q;
	logic signed [ACC_W-1:0] acc_dy_q;
	logic signed [ACC_W-1:0] acc_wheel_q;

	res_t                  obuf_q [OBUF_DEPTH];
	logic [OBUF_PTR_W-1:0] ob_wr_q;
	logic [OBUF_PTR_W-1:0] ob_rd_q;
	logic [OBUF_CNT_W-1:0] ob_cnt_q;

	logic                    ob_full;
	logic                    ob_take;
	logic [CUR_W-1:0]        nx_x;
	logic [CUR_W-1:0]        nx_y;
	logic signed [ACC_W-1:0] nx_dx;
	logic signed [ACC_W-1:0] nx_dy;
	logic signed [ACC_W-1:0] nx_wheel;
	res_t                    res_d;

	assign ob_full   = ob_cnt_q == OBUF_CNT_W'(OBUF_DEPTH);
	assign res_empty = ob_cnt_q == '0;
	assign ob_take   = res_pop && !res_empty;
	// a slot freed by this cycle's pop may be refilled at once
	assign cmd_pop   = !cmd_empty && (!ob_full || ob_take);
	assign res       = obuf_q[ob_rd_q];

	assign nx_x     = move_cursor(cursor_x_q, cmd.dx);
	assign nx_y     = move_cursor(cursor_y_q, cmd.dy);
	assign nx_dx    = sat_add(acc_dx_q, cmd.dx);
	assign nx_dy    = sat_add(acc_dy_q, cmd.dy);
	assign nx_wheel = cmd.use_wheel ? sat_add(acc_wheel_q, DELTA_W'(cmd.wz)) : acc_wheel_q;

	always_comb begin
		res_d.pos_x       = POS_W'(cursor_x_q);
		res_d.pos_y       = POS_W'(cursor_y_q);
		res_d.buttons     = buttons_q;
		res_d.sum_dx      = acc_dx_q;
		res_d.sum_dy      = acc_dy_q;
		res_d.sum_wheel   = acc_wheel_q;
		res_d.packet_done = 1'b0;
		case (cmd.op)
			CMD_PACKET: begin
				res_d.pos_x       = POS_W'(nx_x);
				res_d.pos_y       = POS_W'(nx_y);
				res_d.buttons     = cmd.buttons;
				res_d.sum_dx      = nx_dx;
				res_d.sum_dy      = nx_dy;
				res_d.sum_wheel   = nx_wheel;
				res_d.packet_done = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q  <= CURSOR_RESET;
			cursor_y_q  <= CURSOR_RESET;
			buttons_q   <= '0;
			acc_dx_q    <= '0;
			acc_dy_q    <= '0;
			acc_wheel_q <= '0;
		end else if (cmd_pop) begin
			case (cmd.op)
				CMD_PACKET: begin
					cursor_x_q  <= nx_x;
					cursor_y_q  <= nx_y;
					buttons_q   <= cmd.buttons;
					acc_dx_q    <= nx_dx;
					acc_dy_q    <= nx_dy;
					acc_wheel_q <= nx_wheel;
				end
				CMD_READ: begin
					// report goes out first, clears land after it
					if (cmd.clr_motion) begin
						acc_dx_q <= '0;
						acc_dy_q <= '0;
					end
					if (cmd.clr_wheel)
						acc_wheel_q <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_wr_q  <= '0;
			ob_rd_q  <= '0;
			ob_cnt_q <= '0;
		end else begin
			if (cmd_pop)
				ob_wr_q <= (ob_wr_q == OBUF_PTR_W'(OBUF_DEPTH - 1)) ? '0 : ob_wr_q + 1'b1;
			if (ob_take)
				ob_rd_q <= (ob_rd_q == OBUF_PTR_W'(OBUF_DEPTH - 1)) ? '0 : ob_rd_q + 1'b1;
			if (cmd_pop && !ob_take)
				ob_cnt_q <= ob_cnt_q + 1'b1;
			else if (ob_take && !cmd_pop)
				ob_cnt_q <= ob_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop)
			obuf_q[ob_wr_q] <= res_d;
	end

endmodule

`default_nettype wire

// ----- design/ps2_mouse_packet_decoder.sv -----
`default_nettype none

// channel   direction  handshake            payload
// input     in         push / full          kind, data_byte, clear_motion, clear_wheel
// result    out        empty / pop          pos_x, pos_y, buttons, sum_dx, sum_dy,
//                                           sum_wheel, packet_done
// config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one item per cycle sustained while full is low; every item gives exactly one result
// the front classifies and clamps deltas in the accept cycle, the back applies
// them when it pops the command queue and writes the result to the result queue
// reset leaves the cursor at mid canvas, accumulators and packet index at zero
// two-entry queues on each side let input and result sides stall independently
module ps2_mouse_packet_decoder (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             push,
	output logic                                  full,
	input  wire logic                             kind,
	input  wire logic [7:0]                       data_byte,
	input  wire logic                             clear_motion,
	input  wire logic                             clear_wheel,
	output logic                                  empty,
	input  wire logic                             pop,
	output logic [ps2md_pkg::POS_W-1:0]           pos_x,
	output logic [ps2md_pkg::POS_W-1:0]           pos_y,
	output logic [ps2md_pkg::BTN_W-1:0]           buttons,
	output logic signed [ps2md_pkg::ACC_W-1:0]    sum_dx,
	output logic signed [ps2md_pkg::ACC_W-1:0]    sum_dy,
	output logic signed [ps2md_pkg::ACC_W-1:0]    sum_wheel,
	output logic                                  packet_done,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [ps2md_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ps2md_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ps2md_pkg::*;

	logic             wheel_mode_q;
	logic [LIM_W-1:0] delta_limit_q;

	logic take;
	cmd_t front_cmd;
	cmd_t head_cmd;
	logic cmd_full;
	logic cmd_empty;
	logic cmd_pop;
	res_t res;

	assign cfg_ready = 1'b1;
	assign take      = push && !cmd_full;
	assign full      = cmd_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheel_mode_q  <= 1'b0;
			delta_limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_WHEEL_MODE:  wheel_mode_q  <= cfg_data[0];
				REG_DELTA_LIMIT: delta_limit_q <= cfg_data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	ps2md_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.wheel_mode   (wheel_mode_q),
		.delta_limit  (delta_limit_q),
		.take         (take),
		.kind         (kind),
		.data_byte    (data_byte),
		.clear_motion (clear_motion),
		.clear_wheel  (clear_wheel),
		.cmd          (front_cmd)
	);

	ps2md_cmd_fifo u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (take),
		.wr_data (front_cmd),
		.rd_en   (cmd_pop),
		.rd_data (head_cmd),
		.q_full  (cmd_full),
		.q_empty (cmd_empty)
	);

	ps2md_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (head_cmd),
		.cmd_pop   (cmd_pop),
		.res_pop   (pop),
		.res       (res),
		.res_empty (empty)
	);

	assign pos_x       = res.pos_x;
	assign pos_y       = res.pos_y;
	assign buttons     = res.buttons;
	assign sum_dx      = res.sum_dx;
	assign sum_dy      = res.sum_dy;
	assign sum_wheel   = res.sum_wheel;
	assign packet_done = res.packet_done;

	a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !cmd_empty)
		else $error("back took a command from an empty queue");

	a_take_lands: assert property (@(posedge clk) disable iff (!arst_n)
		take && cmd_empty |=> !cmd_empty)
		else $error("accepted item did not reach the command queue");

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |=> !empty)
		else $error("executed command left no result");

endmodule

`default_nettype wire
